>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the half-step positioner.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in half-step positioner");
// Implication checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed in half-step positioner");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/shsp_pkg.sv
// Package of the half-step positioner: word types, command codes and the coil table.
// No dependencies.
package shsp_pkg;

   localparam int unsigned FIELD_POS_BITS = 24;

   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_RUN   = 3'd1,
      KIND_SEEK  = 3'd2,
      KIND_HOME  = 3'd3,
      KIND_STOP  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]                       kind;
      logic                             run_up;
      logic signed [FIELD_POS_BITS-1:0] target_position;
   } req_type;

   typedef struct packed {
      logic [3:0]                       coils;
      logic signed [FIELD_POS_BITS-1:0] position;
      logic                             running;
      logic                             moving_up;
      logic                             homing;
      logic                             saved;
   } rsp_type;

   // Eight-phase half-step pattern, bit 3 is coil A and bit 0 is coil D.
   function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
      logic [3:0] pat;
      begin
         case (phase)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            3'd7: pat = 4'b1001;
            default: pat = 4'b0000;
         endcase
         return pat;
      end
   endfunction

endpackage

>>> hw/rtl/stepper_half_step_positioner_top.sv
// Channel   Ports                               Direction  Word
// request   req_valid / req_ready / req_data    in         req_type (kind, run_up, target)
// response  rsp_valid / rsp_ready / rsp_data    out        rsp_type (coils, position, flags)
// config    csr_wr_en / csr_wr_data             in         home_steps, no wait, no read-back
//
// Every accepted request word produces exactly one response word, registered as it is
// accepted. The block takes one word per cycle while req_ready is high: the whole state
// update is a single pass of logic between the state registers and the response register.
// A two-entry output stage (response register plus skid register) keeps req_ready high
// while one finished word waits; req_ready drops only when both entries are full.
// Reset is synchronous and active high; it clears all state and sets home_steps to 50000.
//
// Top level of the unipolar half-step stepper positioner.
// Depends on shsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stepper_half_step_positioner_top
   import shsp_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // The target compare runs at the wider of the position counter and the target field.
   localparam int unsigned CMP_BITS =
      (POSITION_BITS > FIELD_POS_BITS) ? POSITION_BITS : FIELD_POS_BITS;

   // Configuration register.
   logic [15:0] home_steps_ff;

   // Motor state.
   logic [2:0]                        phase_ff, phase_in;
   logic [POSITION_BITS-1:0]          position_ff, position_in;
   logic                              run_ff, run_in;
   logic                              up_ff, up_in;
   logic                              seek_ff, seek_in;
   logic                              home_ff, home_in;
   logic [15:0]                       home_left_ff, home_left_in;
   logic signed [FIELD_POS_BITS-1:0]  target_ff, target_in;
   logic [3:0]                        coil_ff, coil_in;
   logic                              saved_in;

   // Output stage.
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    accept;
   logic    take;
   rsp_type result;

   logic signed [CMP_BITS-1:0]       pos_ext;
   logic signed [CMP_BITS-1:0]       tgt_ext;
   logic [FIELD_POS_BITS-1:0]        pos_field;
   logic [15:0]                      home_dec;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign take      = out_valid_ff && rsp_ready;

   assign pos_ext  = CMP_BITS'(signed'(position_ff));
   assign tgt_ext  = CMP_BITS'(target_ff);
   assign home_dec = (home_left_ff != 16'd0) ? (home_left_ff - 16'd1) : 16'd0;

   // The reported position is the low 24 bits of the counter; a narrower counter is
   // shown zero-extended.
   generate
      if (POSITION_BITS >= FIELD_POS_BITS) begin : g_pos_wide
         assign pos_field = position_in[FIELD_POS_BITS-1:0];
      end else begin : g_pos_narrow
         assign pos_field = {{(FIELD_POS_BITS-POSITION_BITS){1'b0}}, position_in};
      end
   endgenerate

   // Next state for one request word.
   always_comb begin
      logic step;
      logic dir_up;
      step         = 1'b0;
      dir_up       = up_ff;
      phase_in     = phase_ff;
      position_in  = position_ff;
      run_in       = run_ff;
      up_in        = up_ff;
      seek_in      = seek_ff;
      home_in      = home_ff;
      home_left_in = home_left_ff;
      target_in    = target_ff;
      coil_in      = coil_ff;
      saved_in     = 1'b0;

      case (req_data.kind)
         KIND_TICK: begin
            if (home_ff) begin
               // Homing always steps backward until the count runs out.
               step         = (home_left_ff != 16'd0);
               dir_up       = 1'b0;
               up_in        = step ? 1'b0 : up_ff;
               home_left_in = home_dec;
            end else if (run_ff) begin
               if (seek_ff && (pos_ext == tgt_ext)) begin
                  // Arrived: no step, stop and flag it.
                  saved_in = 1'b1;
                  run_in   = 1'b0;
                  seek_in  = 1'b0;
               end else begin
                  step = 1'b1;
                  if (seek_ff) begin
                     dir_up = (pos_ext < tgt_ext);
                     up_in  = dir_up;
                  end
               end
            end
         end
         KIND_RUN: begin
            if (!home_ff) begin
               run_in  = 1'b1;
               up_in   = req_data.run_up;
               seek_in = 1'b0;
            end
         end
         KIND_SEEK: begin
            if (!home_ff) begin
               target_in = req_data.target_position;
               seek_in   = 1'b1;
               run_in    = 1'b1;
            end
         end
         KIND_HOME: begin
            home_in      = 1'b1;
            home_left_in = home_steps_ff;
            run_in       = 1'b1;
            up_in        = 1'b0;
            seek_in      = 1'b0;
         end
         KIND_STOP: begin
            run_in       = 1'b0;
            seek_in      = 1'b0;
            home_in      = 1'b0;
            home_left_in = 16'd0;
         end
         default: begin
         end
      endcase

      // A step drives the current phase, then moves phase and position one half-step.
      if (step) begin
         coil_in = coil_pattern(phase_ff);
         if (dir_up) begin
            phase_in    = phase_ff + 3'd1;
            position_in = position_ff + POSITION_BITS'(1);
         end else begin
            phase_in    = phase_ff - 3'd1;
            position_in = position_ff - POSITION_BITS'(1);
         end
      end

      // Homing finishes once the count is spent, on the stepping tick itself.
      if ((req_data.kind == KIND_TICK) && home_ff && (home_dec == 16'd0)) begin
         home_in     = 1'b0;
         run_in      = 1'b0;
         position_in = '0;
         phase_in    = 3'd0;
         saved_in    = 1'b1;
      end
   end

   always_comb begin
      result.coils     = coil_in;
      result.position  = pos_field;
      result.running   = run_in;
      result.moving_up = up_in;
      result.homing    = home_in;
      result.saved     = saved_in;
   end

   // Output stage: the response register, backed by a skid register when it is stalled.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_steps_ff <= 16'd50000;
         phase_ff      <= 3'd0;
         position_ff   <= '0;
         run_ff        <= 1'b0;
         up_ff         <= 1'b0;
         seek_ff       <= 1'b0;
         home_ff       <= 1'b0;
         home_left_ff  <= 16'd0;
         target_ff     <= '0;
         coil_ff       <= 4'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            home_steps_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            position_ff  <= position_in;
            run_ff       <= run_in;
            up_ff        <= up_in;
            seek_ff      <= seek_in;
            home_ff      <= home_in;
            home_left_ff <= home_left_in;
            target_ff    <= target_in;
            coil_ff      <= coil_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // The skid register only fills behind a full response register.
   `ASSERT_ALWAYS(a_skid_behind_out, clock, skid_valid_ff |-> out_valid_ff)
   // Homing is a backward run with no target.
   `ASSERT_CLK(a_home_state, clock, reset, home_ff |-> (run_ff && !up_ff && !seek_ff))
   // A saved pulse always reports a stopped motor.
   `ASSERT_CLK(a_saved_stopped, clock, reset,
      (out_valid_ff && out_ff.saved) |-> (!out_ff.running && !out_ff.homing))
   // A stalled response word stays put until it is taken.
   `ASSERT_CLK(a_out_hold, clock, reset,
      ($past(out_valid_ff) && !$past(rsp_ready)) |-> (out_valid_ff && $stable(out_ff)))

endmodule

>>> tb/tb_stepper_half_step_positioner_top.sv
// Self-checking testbench for the half-step stepper positioner: directed and random request
// words, with a built-in predictor, random idling on both channels and one long output hold.
// Depends on shsp_pkg and the RTL of stepper_half_step_positioner_top.
module tb_stepper_half_step_positioner_top;
   import shsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned IDLE_PERCENT = 18;
   localparam int unsigned UNBROKEN_TICKS = 80;
   localparam int unsigned RANDOM_WORDS = 125;
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
   localparam logic [15:0] HOME_STEPS_RESET = 16'd50000;
   localparam logic [15:0] HOME_STEPS_MAX = 16'hFFFF;
   localparam logic [23:0] POS_MAX = 24'h7FFFFF;
   localparam logic [23:0] POS_MIN = 24'h800000;
   // Half-step coil patterns, phase 0 in the low nibble.
   localparam logic [31:0] COIL_SEQUENCE = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // Predicted motor state, updated as each request word is accepted.
   logic [2:0]  drive_phase;
   logic [23:0] drive_pos;
   logic        drive_run;
   logic        drive_up;
   logic        drive_seek;
   logic        drive_home;
   logic [15:0] home_remaining;
   logic [23:0] target_pos;
   logic [3:0]  coil_last;
   logic [15:0] home_steps_cfg;

   // Responses predicted but not yet returned by the block, oldest first.
   rsp_type     due_reports[$];

   bit          send_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int unsigned hold_request = 0;
   int unsigned hold_count = 0;
   int unsigned cycle_count = 0;
   int unsigned words_sent = 0;
   int unsigned reports_checked = 0;
   int unsigned pulses_predicted = 0;
   int unsigned mismatches = 0;

   stepper_half_step_positioner_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Watchdog: a correct run finishes far below this count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.", cycle_count,
                  due_reports.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One half-step in the current direction. The pattern of the phase being left is what
   // the coils show, matching the block's drive-then-advance order.
   function automatic void step_once();
      coil_last = COIL_SEQUENCE[{drive_phase, 2'b00} +: 4];
      if (drive_up) begin
         drive_phase = drive_phase + 3'd1;
         drive_pos = drive_pos + 24'd1;
      end else begin
         drive_phase = drive_phase - 3'd1;
         drive_pos = drive_pos - 24'd1;
      end
   endfunction

   // Applies one accepted request word to the predicted state and returns the response
   // word the block should produce for it.
   function automatic rsp_type predict_half_step(input req_type w);
      rsp_type r;
      logic    arrived;
      arrived = 1'b0;
      case (w.kind)
         KIND_TICK: begin
            if (drive_home) begin
               // Homing always steps backward; a zero count ends it without a step.
               if (home_remaining != 16'd0) begin
                  drive_up = 1'b0;
                  step_once();
                  home_remaining = home_remaining - 16'd1;
               end
               if (home_remaining == 16'd0) begin
                  drive_home = 1'b0;
                  drive_run = 1'b0;
                  drive_pos = '0;
                  drive_phase = '0;
                  arrived = 1'b1;
               end
            end else if (drive_run) begin
               if (drive_seek) begin
                  // On arrival no step is taken; otherwise steer by signed compare.
                  if (drive_pos == target_pos) begin
                     arrived = 1'b1;
                     drive_run = 1'b0;
                     drive_seek = 1'b0;
                  end else begin
                     drive_up = $signed(drive_pos) < $signed(target_pos);
                  end
               end
               if (drive_run) begin
                  step_once();
               end
            end
         end
         KIND_RUN: begin
            if (!drive_home) begin
               drive_run = 1'b1;
               drive_up = w.run_up;
               drive_seek = 1'b0;
            end
         end
         KIND_SEEK: begin
            if (!drive_home) begin
               target_pos = w.target_position;
               drive_seek = 1'b1;
               drive_run = 1'b1;
            end
         end
         KIND_HOME: begin
            drive_home = 1'b1;
            home_remaining = home_steps_cfg;
            drive_run = 1'b1;
            drive_up = 1'b0;
            drive_seek = 1'b0;
         end
         KIND_STOP: begin
            drive_run = 1'b0;
            drive_seek = 1'b0;
            drive_home = 1'b0;
            home_remaining = '0;
         end
         default: begin
         end
      endcase
      if (arrived) begin
         pulses_predicted++;
      end
      r.coils = coil_last;
      r.position = drive_pos;
      r.running = drive_run;
      r.moving_up = drive_up;
      r.homing = drive_home;
      r.saved = arrived;
      return r;
   endfunction

   function automatic req_type make_word(input logic [2:0] k, input logic up,
                                         input logic [23:0] t);
      req_type w;
      w.kind = k;
      w.run_up = up;
      w.target_position = t;
      return w;
   endfunction

   // Offers one word and returns at the edge where it is accepted. Valid is only lowered
   // when an idle gap is inserted, so back-to-back words keep it high without a glitch.
   task automatic offer_word(input req_type w);
      if (send_idle_on) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      due_reports.push_back(predict_half_step(w));
      words_sent++;
   endtask

   // Step ticks carry random values in the fields the block ignores for them.
   task automatic send_ticks(input int unsigned n);
      repeat (n) begin
         offer_word(make_word(KIND_TICK, 1'($urandom), 24'($urandom)));
      end
   endtask

   // The sender stops and waits until every predicted response has been returned.
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // The register is only written with the block idle.
   task automatic write_home_steps(input logic [15:0] v);
      drain_reports();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      home_steps_cfg = v;
      csr_wr_en <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Response side: a requested hold keeps ready low for a counted stretch, otherwise
   // ready drops at random while idling is enabled.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count != 0) begin
         hold_count = hold_count - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(rsp_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   task automatic report_field(input string label, input logic [23:0] want,
                               input logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Every accepted response word is compared with the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_reports.size() == 0) begin
            $display("%0t: response with nothing expected, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = due_reports.pop_front();
            report_field("coils", 24'(want.coils), 24'(rsp_data.coils));
            report_field("position", want.position, rsp_data.position);
            report_field("running", 24'(want.running), 24'(rsp_data.running));
            report_field("moving_up", 24'(want.moving_up), 24'(rsp_data.moving_up));
            report_field("homing", 24'(want.homing), 24'(rsp_data.homing));
            report_field("saved", 24'(want.saved), 24'(rsp_data.saved));
         end
         reports_checked++;
      end
   end

   // Ticks while stopped leave the coils off, and spare kinds only report the state.
   task automatic test_stopped_and_spare_kinds();
      send_ticks(1);
      offer_word(make_word(KIND_SPARE_FIRST, 1'b1, POS_MAX));
      offer_word(make_word(KIND_SPARE_LAST, 1'b0, POS_MIN));
      offer_word(make_word(KIND_STOP, 1'b1, '1));
      drain_reports();
   endtask

   // Free run walks through all eight phases upward, reverses, then stops; the coils
   // keep the last pattern on a stopped tick.
   task automatic test_free_run();
      offer_word(make_word(KIND_RUN, 1'b1, '0));
      send_ticks(8);
      offer_word(make_word(KIND_RUN, 1'b0, '1));
      send_ticks(2);
      offer_word(make_word(KIND_STOP, 1'b0, '0));
      send_ticks(1);
      drain_reports();
   endtask

   // Move-to a nearby target up to arrival, then toward both extremes of the range,
   // which exercises the signed compare in both directions.
   task automatic test_move_to();
      offer_word(make_word(KIND_SEEK, 1'b0, drive_pos + 24'd2));
      send_ticks(4);
      offer_word(make_word(KIND_SEEK, 1'b1, POS_MIN));
      send_ticks(2);
      offer_word(make_word(KIND_SEEK, 1'b0, POS_MAX));
      send_ticks(2);
      offer_word(make_word(KIND_STOP, 1'b1, '0));
      drain_reports();
   endtask

   // Homing with the count left at its reset value, in a long stretch with no idling at
   // all; it is stopped well before the count runs out.
   task automatic test_default_homing();
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      offer_word(make_word(KIND_HOME, 1'b1, '0));
      send_ticks(UNBROKEN_TICKS);
      offer_word(make_word(KIND_STOP, 1'b0, '0));
      drain_reports();
   endtask

   // Run and move-to are ignored while homing, homing restarts its count, stop aborts
   // without zeroing, and a count of zero or one ends on the first tick.
   task automatic test_homing_commands();
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_home_steps(16'd2);
      offer_word(make_word(KIND_RUN, 1'b1, '0));
      send_ticks(3);
      offer_word(make_word(KIND_HOME, 1'b1, '0));
      offer_word(make_word(KIND_RUN, 1'b1, '0));
      offer_word(make_word(KIND_SEEK, 1'b1, 24'd100));
      send_ticks(1);
      offer_word(make_word(KIND_HOME, 1'b0, '0));
      send_ticks(2);
      offer_word(make_word(KIND_HOME, 1'b0, '0));
      send_ticks(1);
      offer_word(make_word(KIND_STOP, 1'b0, '0));
      write_home_steps(16'd0);
      offer_word(make_word(KIND_HOME, 1'b0, '0));
      send_ticks(1);
      write_home_steps(16'd1);
      offer_word(make_word(KIND_HOME, 1'b0, '0));
      send_ticks(1);
      drain_reports();
   endtask

   // Homing started at the largest count and stopped part way, with both sides always
   // ready.
   task automatic test_full_homing();
      write_home_steps(HOME_STEPS_MAX);
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      offer_word(make_word(KIND_HOME, 1'b0, '0));
      send_ticks(12);
      offer_word(make_word(KIND_STOP, 1'b0, '0));
      drain_reports();
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off long enough for the output stage to fill, so req_ready must
   // drop while words keep being offered.
   task automatic test_backpressure();
      offer_word(make_word(KIND_RUN, 1'b1, '0));
      hold_request = 150;
      send_ticks(40);
      offer_word(make_word(KIND_STOP, 1'b0, '0));
      drain_reports();
   endtask

   // Random traffic, mostly ticks after move-to commands with targets close to the
   // current position, so arrivals and short homing runs happen often. Far and extreme
   // targets, stops, spare kinds and occasional full pauses mix in.
   task automatic test_random_phase(input int unsigned n, input logic [15:0] hs);
      int unsigned done;
      int unsigned pick;
      logic [2:0]  k;
      logic [23:0] tgt;
      write_home_steps(hs);
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         tgt = 24'($urandom);
         if (pick < 80) begin
            tgt = drive_pos + 24'($urandom_range(0, 64)) - 24'd32;
         end else if (pick < 84) begin
            tgt = ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            k = KIND_TICK;
         end else if (pick < 68) begin
            k = KIND_RUN;
         end else if (pick < 80) begin
            k = KIND_SEEK;
         end else if (pick < 86) begin
            k = KIND_HOME;
         end else if (pick < 91) begin
            k = KIND_STOP;
         end else if (pick < 94) begin
            k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         end else begin
            k = KIND_TICK;
         end
         offer_word(make_word(k, 1'($urandom), tgt));
         if (k <= KIND_STOP) begin
            done++;
         end
         if ($urandom_range(0, 199) == 0) begin
            drain_reports();
         end
      end
      drain_reports();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      drive_phase = '0;
      drive_pos = '0;
      drive_run = 1'b0;
      drive_up = 1'b0;
      drive_seek = 1'b0;
      drive_home = 1'b0;
      home_remaining = '0;
      target_pos = '0;
      coil_last = '0;
      home_steps_cfg = HOME_STEPS_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      test_stopped_and_spare_kinds();
      test_free_run();
      test_move_to();
      test_default_homing();
      test_homing_commands();
      test_full_homing();
      test_backpressure();
      test_random_phase(RANDOM_WORDS, 16'd1);
      test_random_phase(RANDOM_WORDS, 16'($urandom_range(2, 12)));
      test_random_phase(RANDOM_WORDS, 16'($urandom_range(13, 40)));
      test_random_phase(RANDOM_WORDS, 16'd0);

      drain_reports();
      repeat (10) @(posedge clock);
      $display("Sent %0d words: stopped and spare kinds, free run, move-to, homing at counts",
               words_sent);
      $display("0 to 65535, a long output hold; %0d responses checked, %0d pulses expected.",
               reports_checked, pulses_predicted);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
